[hdl/u8u16_pkg.sv]
// u8u16_pkg: shared widths, constants and struct types of the UTF-8 to UTF-16 transcoder.
// No dependencies; every other file of the block depends on it.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

	localparam int BYTE_W      = 8;
	localparam int POINT_W     = 21;
	localparam int UNIT_W      = 16;
	localparam int PEND_W      = 2;
	localparam int QUEUE_DEPTH = 4;

	// UTF-16 mapping constants
	localparam logic [POINT_W-1:0] BMP_MAX      = 21'h00FFFF;
	localparam logic [POINT_W-1:0] SUPP_BASE    = 21'h010000;
	localparam logic [UNIT_W-1:0]  HI_SURR_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0]  LO_SURR_BASE = 16'hDC00;

	// finished code point from the decoder into the queue
	typedef struct packed {
		logic               push;
		logic [POINT_W-1:0] point;
	} point_push_t;

	// queue head as the back end sees it
	typedef struct packed {
		logic               valid;
		logic               full;
		logic [POINT_W-1:0] point;
	} queue_stat_t;

endpackage

`default_nettype wire

[hdl/u8u16_if.sv]
// u8u16_byte_if / u8u16_unit_if: valid/ready channels for input bytes and output code units.
// Depends on u8u16_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface u8u16_byte_if;
	logic                         valid;
	logic                         ready;
	logic [u8u16_pkg::BYTE_W-1:0] in_byte;
	logic                         string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface u8u16_unit_if;
	logic                         valid;
	logic                         ready;
	logic [u8u16_pkg::UNIT_W-1:0] code_unit;
	logic                         run_last;

	modport source (output valid, output code_unit, output run_last, input ready);
	modport sink   (input valid, input code_unit, input run_last, output ready);
endinterface

`default_nettype wire

[hdl/u8u16_front.sv]
// u8u16_front: accepts UTF-8 byte beats and assembles code points (lax decoder).
// Depends on u8u16_pkg and u8u16_byte_if; pushes finished points into the queue.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
	input  wire                      clk,
	input  wire                      arst_n,
	u8u16_byte_if.sink               bytes,
	input  wire                      queue_full,
	output u8u16_pkg::point_push_t   push
);
	import u8u16_pkg::*;

	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'b1111_0000;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'b1110_0000;
	localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
	localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
	localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

	logic [POINT_W-1:0] point_q;
	logic [PEND_W-1:0]  pend_q;
	logic               accept;
	logic               is_lead4;
	logic               is_lead3;
	logic [POINT_W-1:0] cont_point;

	assign bytes.ready = !queue_full;
	assign accept      = bytes.valid && bytes.ready;

	assign is_lead4   = (bytes.in_byte & LEAD4_MASK) == LEAD4_MASK;
	assign is_lead3   = (bytes.in_byte & LEAD3_MASK) == LEAD3_MASK;
	// continuation: shift in six payload bits, top bits fall off
	assign cont_point = {point_q[POINT_W-7:0], bytes.in_byte[5:0]};

	// a point is finished by the last continuation or by a one-byte character
	always_comb begin
		push.push  = accept && !bytes.string_end &&
			((pend_q == PEND_ONE) || (pend_q == PEND_NONE && !bytes.in_byte[7]));
		push.point = (pend_q != PEND_NONE) ? cont_point
			: {{(POINT_W-BYTE_W){1'b0}}, bytes.in_byte};
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q <= '0;
			pend_q  <= PEND_NONE;
		end else if (accept) begin
			if (bytes.string_end) begin
				point_q <= '0;
				pend_q  <= PEND_NONE;
			end else if (pend_q != PEND_NONE) begin
				point_q <= (pend_q == PEND_ONE) ? '0 : cont_point;
				pend_q  <= pend_q - PEND_ONE;
			end else if (bytes.in_byte[7]) begin
				if (is_lead4) begin
					point_q <= {{(POINT_W-3){1'b0}}, bytes.in_byte[2:0]};
					pend_q  <= PEND_THREE;
				end else if (is_lead3) begin
					point_q <= {{(POINT_W-4){1'b0}}, bytes.in_byte[3:0]};
					pend_q  <= PEND_TWO;
				end else begin
					point_q <= {{(POINT_W-5){1'b0}}, bytes.in_byte[4:0]};
					pend_q  <= PEND_ONE;
				end
			end
		end
	end

endmodule

`default_nettype wire

[hdl/u8u16_fifo.sv]
// u8u16_fifo: short queue of finished code points between decoder and unit emitter.
// Depends on u8u16_pkg for the point width and queue structs.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_fifo #(
	parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  u8u16_pkg::point_push_t   push,
	input  wire                      pop,
	output u8u16_pkg::queue_stat_t   stat
);
	import u8u16_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [POINT_W-1:0] entries_q [DEPTH];
	logic [IDX_W-1:0]   wr_ptr_q;
	logic [IDX_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.valid = count_q != '0;
	assign stat.full  = count_q == FULL_CNT;
	assign stat.point = entries_q[rd_ptr_q];

	assign do_push = push.push && !stat.full;
	assign do_pop  = pop && stat.valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push.point;
	end

endmodule

`default_nettype wire

[hdl/u8u16_back.sv]
// u8u16_back: turns queued code points into UTF-16 units, one unit beat per cycle while the sink is ready.
// Depends on u8u16_pkg and u8u16_unit_if; pops the point queue.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  u8u16_pkg::queue_stat_t   stat,
	output logic                     pop,
	u8u16_unit_if.source             units
);
	import u8u16_pkg::*;

	logic               ovalid_q;
	logic [UNIT_W-1:0]  unit_q;
	logic               last_q;
	logic               lo_pend_q;
	logic [UNIT_W-1:0]  lo_q;
	logic               load;
	logic               is_bmp;
	logic [POINT_W-1:0] supp;
	logic [UNIT_W-1:0]  hi_unit;
	logic [UNIT_W-1:0]  lo_unit;

	assign units.valid     = ovalid_q;
	assign units.code_unit = unit_q;
	assign units.run_last  = last_q;

	// output register takes a new beat when empty or being drained
	assign load = !ovalid_q || units.ready;
	assign pop  = load && !lo_pend_q && stat.valid;

	// surrogate split; high half is supp[20:10] zero-extended to 16 bits
	assign is_bmp  = stat.point <= BMP_MAX;
	assign supp    = stat.point - SUPP_BASE;
	assign hi_unit = UNIT_W'(supp[POINT_W-1:10]) + HI_SURR_BASE;
	assign lo_unit = {6'b0, supp[9:0]} + LO_SURR_BASE;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q  <= 1'b0;
			lo_pend_q <= 1'b0;
		end else if (load) begin
			if (lo_pend_q) begin
				ovalid_q  <= 1'b1;
				lo_pend_q <= 1'b0;
			end else if (stat.valid) begin
				ovalid_q  <= 1'b1;
				lo_pend_q <= !is_bmp;
			end else begin
				ovalid_q  <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (lo_pend_q) begin
				unit_q <= lo_q;
				last_q <= 1'b1;
			end else if (stat.valid) begin
				unit_q <= is_bmp ? stat.point[UNIT_W-1:0] : hi_unit;
				last_q <= is_bmp;
				lo_q   <= lo_unit;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/utf8_to_utf16_transcoder.sv]
// UTF-8 to UTF-16 transcoder, top level: decoder front, point queue, unit emitter back.
// Throughput: one byte beat per cycle while the queue is not full; a surrogate pair takes two output beats at the back.
// A code point finished by a byte beat is first written into the queue, then loaded into the
// output register, which drives the unit.
// Reset: arst_n asynchronously clears decoder state, queue and output valid.
// Depends on u8u16_pkg, u8u16_if, u8u16_front, u8u16_fifo and u8u16_back.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_transcoder #(
	parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
	input  wire            clk,
	input  wire            arst_n,
	u8u16_byte_if.sink     bytes,
	u8u16_unit_if.source   units
);
	import u8u16_pkg::*;

	point_push_t push;
	queue_stat_t stat;
	logic        pop;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.queue_full (stat.full),
		.push       (push)
	);

	u8u16_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (stat)
	);

	u8u16_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.pop    (pop),
		.units  (units)
	);

`ifndef SYNTHESIS
	// the decoder never pushes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !stat.full)
		else $error("point pushed into full queue");

	// the emitter never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.valid)
		else $error("point popped from empty queue");

	// a high surrogate beat is followed at once by its low half
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		units.valid && units.ready && !units.run_last |=> units.valid && units.run_last)
		else $error("low surrogate missing after high half");
`endif

endmodule

`default_nettype wire
